FILE: rtl/core/itar_pkg.sv
// Shared types and constants for the integer to ASCII radix converter.
// No dependencies; imported by itar_div and integer_to_ascii_radix_top.
package itar_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = $clog2(DATA_W);

    // Radix limits and the one radix that carries a sign.
    localparam logic [4:0] RADIX_MIN   = 5'd2;
    localparam logic [4:0] RADIX_MAX   = 5'd16;
    localparam logic [4:0] RADIX_DEC   = 5'd10;
    localparam logic [4:0] RADIX_RESET = 5'd10;

    // At most one digit per bit of the magnitude.
    localparam logic [5:0] MAX_DIGITS = 6'd32;

    localparam logic [6:0] ASCII_MINUS = 7'h2d;
    localparam logic [6:0] ASCII_NUL   = 7'h00;

    // Register index decoded from the byte address.
    localparam logic REG_RADIX = 1'b0;

    // Digit value to lower-case ASCII.
    localparam logic [6:0] DIGIT_CHARS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_DIGITS,
        ST_EMPTY
    } itar_state_t;

    // Result of one bit-serial division, shown for one cycle with done.
    typedef struct packed {
        logic              done;
        logic [3:0]        digit;
        logic              quot_zero;
        logic [DATA_W-1:0] quot;
    } itar_div_res_t;

endpackage

FILE: rtl/core/itar_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, radix 2 to 16.
// Depends on itar_pkg.
module itar_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [itar_pkg::DATA_W-1:0] dividend,
    input  logic [4:0]                  radix,
    output itar_pkg::itar_div_res_t     res
);
    import itar_pkg::*;

    logic [DATA_W-1:0] q_reg;
    logic [4:0]        rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              nz_reg;

    logic [5:0] trial;
    logic [5:0] diff;
    logic       ge;

    // One partial remainder step: shift in the next dividend bit, subtract if possible.
    always_comb begin
        trial = {rem_reg, q_reg[DATA_W-1]};
        diff  = trial - {1'b0, radix};
        ge    = (trial >= {1'b0, radix});
    end

    // Control: busy for one pass over all dividend bits, then a done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits enter at the bottom as dividend bits leave the top.
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            nz_reg  <= 1'b0;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[DATA_W-2:0], ge};
            rem_reg <= ge ? diff[4:0] : trial[4:0];
            nz_reg  <= nz_reg | ge;
        end
    end

    assign res.done      = done_reg;
    assign res.digit     = rem_reg[3:0];
    assign res.quot_zero = !nz_reg;
    assign res.quot      = q_reg;

endmodule

FILE: rtl/core/integer_to_ascii_radix_top.sv
// Top level of the integer to ASCII radix converter.
// Depends on itar_pkg and itar_div.
//
// Usage:
//   The slave channel takes one signed 32-bit integer per item on s_tdata.
//   The master channel returns its text, one ASCII character per item,
//   most significant first, in the base held in the radix register
//   (APB address 0, reset value 10). m_tlast marks the last character.
//   In base 10 a negative value is preceded by '-'; in other bases the
//   digits of the magnitude are sent without a sign. A radix outside
//   2 to 16 gives one item with character 0 and m_tuser set.
// Operation:
//   Digits are produced by a bit-serial divider and stacked; the stack is
//   then sent one character per cycle while m_tready is high. One item is
//   in work at a time; s_tready is high only between items.
// Reset and stall:
//   aresetn (synchronous, active low) empties the output register, returns
//   the sequencer to idle and sets radix to 10. When m_tready is low the
//   current character holds in the output register and the sequencer waits.
module integer_to_ascii_radix_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Slave channel; s_tdata: number_in [31:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // Master channel; m_tdata: char_code [6:0], zero [7]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    // m_tuser: empty_result [0]
    output logic        m_tuser,
    output logic        m_tlast,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import itar_pkg::*;

    itar_state_t   state_reg, state_next;
    itar_div_res_t div_res;

    logic [4:0]        radix_reg;
    logic              neg_reg;
    logic [5:0]        ndig_reg;
    logic [3:0]        stack_reg [MAX_DIGITS];

    logic              out_valid_reg;
    logic [6:0]        out_char_reg;
    logic              out_empty_reg;
    logic              out_last_reg;

    logic              radix_ok;
    logic              slot_free;
    logic              more_digits;
    logic [DATA_W-1:0] magnitude;

    // Sequencer outputs.
    logic              div_start;
    logic [DATA_W-1:0] div_dividend;
    logic              push;
    logic              pop;
    logic              out_load;
    logic [6:0]        out_char;
    logic              out_empty;
    logic              out_last;

    assign radix_ok    = (radix_reg >= RADIX_MIN) && (radix_reg <= RADIX_MAX);
    assign slot_free   = !out_valid_reg || m_tready;
    assign magnitude   = s_tdata[DATA_W-1] ? (DATA_W'(0) - s_tdata) : s_tdata;
    assign more_digits = !div_res.quot_zero && (ndig_reg != MAX_DIGITS - 6'd1);

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RADIX) ? {27'd0, radix_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RADIX)) begin
            radix_reg <= pwdata[4:0];
        end
    end

    // Digit generator.
    itar_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .radix    (radix_reg),
        .res      (div_res)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = radix_ok ? ST_DIV : ST_EMPTY;
                end
            end
            ST_DIV: begin
                if (div_res.done && !more_digits) begin
                    state_next = (neg_reg && radix_reg == RADIX_DEC) ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (slot_free && ndig_reg == 6'd1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready     = 1'b0;
        div_start    = 1'b0;
        div_dividend = magnitude;
        push         = 1'b0;
        pop          = 1'b0;
        out_load     = 1'b0;
        out_char     = ASCII_NUL;
        out_empty    = 1'b0;
        out_last     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && radix_ok) begin
                    div_start = 1'b1;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    push = 1'b1;
                    if (more_digits) begin
                        div_start    = 1'b1;
                        div_dividend = div_res.quot;
                    end
                end
            end
            ST_SIGN: begin
                out_load = slot_free;
                out_char = ASCII_MINUS;
            end
            ST_DIGITS: begin
                out_load = slot_free;
                pop      = slot_free;
                out_char = DIGIT_CHARS[stack_reg[0]];
                out_last = (ndig_reg == 6'd1);
            end
            ST_EMPTY: begin
                out_load  = slot_free;
                out_empty = 1'b1;
                out_last  = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ndig_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_tvalid && s_tready) begin
                ndig_reg <= '0;
            end else if (push) begin
                ndig_reg <= ndig_reg + 6'd1;
            end else if (pop) begin
                ndig_reg <= ndig_reg - 6'd1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Sign flag and output payload.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            neg_reg <= s_tdata[DATA_W-1];
        end
        if (out_load) begin
            out_char_reg  <= out_char;
            out_empty_reg <= out_empty;
            out_last_reg  <= out_last;
        end
    end

    // Digit stack: digits arrive least significant first and leave from the top.
    always_ff @(posedge aclk) begin
        if (push) begin
            stack_reg[0] <= div_res.digit;
            for (int i = 1; i < int'(MAX_DIGITS); i++) begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < int'(MAX_DIGITS) - 1; i++) begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tuser  = out_empty_reg;
    assign m_tlast  = out_last_reg;

    // The digit count never exceeds the stack depth.
    a_ndig_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ndig_reg <= MAX_DIGITS)
        else $error("digit count beyond stack depth");

    // Digits are only sent while the stack holds at least one.
    a_digits_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIGITS |-> ndig_reg != 6'd0)
        else $error("sending digits from an empty stack");

    // A finished division is only seen while digits are being collected.
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> state_reg == ST_DIV)
        else $error("division finished outside digit collection");

    // An empty result is always the last item of its run.
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("empty result not marked last");

endmodule

FILE: tb/sv/integer_to_ascii_radix_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_ascii_radix_top: numbers go in on the slave stream
// and the ASCII text that comes back is checked against a predicted copy of it.
// Depends on itar_pkg and on the RTL of the converter.
module integer_to_ascii_radix_top_tb;

    import itar_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned TARGET_ITEMS = 230;
    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;
    localparam logic [2:0] ADDR_RADIX = {REG_RADIX, 2'b00};
    localparam logic [2:0] ADDR_UNUSED = {~REG_RADIX, 2'b00};

    // One character of expected text.
    typedef struct {
        logic [6:0] char_code;
        logic       empty_result;
        logic       last_char;
    } text_char_t;

    // Predicts the text of each accepted number and checks the characters that come back.
    class ascii_text_board;
        logic [4:0] radix;
        text_char_t expected_chars[$];
        int unsigned errors;

        function new();
            radix = RADIX_RESET;
            errors = 0;
        endfunction

        function int unsigned pending();
            return expected_chars.size();
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= 10) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endfunction

        // Only register index 0 exists; writes elsewhere are dropped.
        function void write_register(int unsigned index, logic [31:0] value);
            if (index == 0) begin
                radix = value[4:0];
            end
        endfunction

        function void check_radix(logic [31:0] rdata);
            if (rdata !== {27'b0, radix}) begin
                flag_error($sformatf("radix read expected %0d, got %h", radix, rdata));
            end
        endfunction

        // Works out the whole text for one number, most significant character first.
        function void note_number(logic [31:0] number);
            text_char_t ch;
            text_char_t digits[$];
            int unsigned mag;
            int unsigned divisor;
            int unsigned digit_val;
            if (radix < RADIX_MIN || radix > RADIX_MAX) begin
                ch.char_code = ASCII_NUL;
                ch.empty_result = 1'b1;
                ch.last_char = 1'b1;
                expected_chars.push_back(ch);
                return;
            end
            divisor = 32'(radix);
            mag = number[31] ? (32'd0 - number) : number;
            ch.empty_result = 1'b0;
            ch.last_char = 1'b0;
            do begin
                digit_val = mag % divisor;
                ch.char_code = (digit_val < 10) ? CHAR_ZERO + 7'(digit_val)
                                                : CHAR_LOWER_A + 7'(digit_val - 10);
                digits.push_front(ch);
                mag = mag / divisor;
            end while (mag != 0);
            // Only base ten carries a sign.
            if (number[31] && radix == RADIX_DEC) begin
                ch.char_code = ASCII_MINUS;
                digits.push_front(ch);
            end
            digits[digits.size() - 1].last_char = 1'b1;
            foreach (digits[i]) begin
                expected_chars.push_back(digits[i]);
            end
        endfunction

        function void check_char(logic [7:0] tdata, logic tuser, logic tlast);
            text_char_t want;
            if (expected_chars.size() == 0) begin
                flag_error($sformatf("unexpected item tdata %h tuser %b tlast %b",
                                     tdata, tuser, tlast));
                return;
            end
            want = expected_chars.pop_front();
            if (tdata !== {1'b0, want.char_code} || tuser !== want.empty_result
                    || tlast !== want.last_char) begin
                flag_error($sformatf("expected tdata %h tuser %b tlast %b, got %h %b %b",
                                     {1'b0, want.char_code}, want.empty_result,
                                     want.last_char, tdata, tuser, tlast));
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ascii_text_board board;
    bit              idling_on;
    int unsigned     cycle_count;
    int unsigned     items_sent;
    int unsigned     stall_left;

    integer_to_ascii_radix_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run time guard.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("integer_to_ascii_radix_top verification failed");
            $finish;
        end
    end

    // Result side: random stall bursts while idling is on, otherwise always ready.
    initial begin
        m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 11) == 0) begin
                m_tready = 1'b0;
                stall_left = $urandom_range(1, 18) - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Every accepted result item is checked at the edge that takes it.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_char(m_tdata, m_tuser, m_tlast);
        end
    end

    // One APB transfer; called and returns just after a falling edge.
    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] data, output logic [31:0] rdata);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = addr;
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (wr) begin
            board.write_register(32'(addr >> 2), data);
        end
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Waits for all text to arrive, then writes an address and reads the radix back.
    task automatic write_config(input logic [2:0] addr, input logic [4:0] value);
        logic [31:0] rdata;
        logic [31:0] wdata;
        while (board.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        wdata = $urandom_range(0, 1) ? {$urandom} : 32'd0;
        wdata[4:0] = value;
        apb_access(1'b1, addr, wdata, rdata);
        apb_access(1'b0, ADDR_RADIX, 32'd0, rdata);
        board.check_radix(rdata);
    endtask

    // Offers one number and holds it until the converter takes it.
    task automatic send_number(input logic [31:0] number);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = number;
        do @(posedge aclk); while (!s_tready);
        board.note_number(number);
        items_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Random, small and extreme numbers, and the magnitudes that change the digit count in this base.
    function automatic logic [31:0] pick_number(input logic [4:0] radix_val);
        logic [31:0] pow;
        int unsigned divisor;
        divisor = (radix_val < RADIX_MIN || radix_val > RADIX_MAX) ? 10 : 32'(radix_val);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 40);
            2: return 32'd0 - $urandom_range(1, 40);
            3: begin
                pow = 1;
                repeat ($urandom_range(1, 31)) begin
                    if (pow <= 32'hffff_ffff / divisor) pow = pow * divisor;
                end
                pow = pow - $urandom_range(0, 1);
                return $urandom_range(0, 3) == 0 ? 32'd0 - pow : pow;
            end
            4: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return 32'd0;
                endcase
            end
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    initial begin
        logic [31:0] rdata;
        logic [4:0]  radix_val;
        int unsigned phase_items;
        board = new();
        idling_on = 1'b1;
        items_sent = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // The radix comes out of reset as ten.
        apb_access(1'b0, ADDR_RADIX, 32'd0, rdata);
        board.check_radix(rdata);

        // Base ten: zero, signs and the extremes of the input.
        send_number(32'd0);
        send_number(32'd1);
        send_number(32'hffff_ffff);
        send_number(32'h7fff_ffff);
        send_number(32'h8000_0000);
        send_number(32'd10);
        send_number(32'd0 - 32'd10);
        send_number(32'd123456789);

        // A write to an address with no register leaves the radix alone.
        write_config(ADDR_UNUSED, 5'd2);
        send_number(32'd0 - 32'd5);

        // Base two: the most negative input gives the longest text.
        write_config(ADDR_RADIX, RADIX_MIN);
        send_number(32'h8000_0000);
        send_number(32'hffff_ffff);
        send_number(32'd5);

        // Base sixteen: letters, and negatives without a sign.
        write_config(ADDR_RADIX, RADIX_MAX);
        send_number(32'hdead_beef);
        send_number(32'h7fff_ffff);
        send_number(32'd255);
        send_number(32'hffff_ffff);

        // Invalid bases give one empty item each.
        write_config(ADDR_RADIX, 5'd0);
        send_number(32'd7);
        write_config(ADDR_RADIX, 5'd1);
        send_number(32'd7);
        write_config(ADDR_RADIX, 5'd17);
        send_number(32'd7);
        write_config(ADDR_RADIX, 5'd31);
        send_number(32'hffff_ffff);

        // Random phases, each under a fresh radix; the last stretch runs without idling.
        while (items_sent < TARGET_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                radix_val = $urandom_range(0, 1) ? 5'($urandom_range(0, 1))
                                                 : 5'($urandom_range(17, 31));
            end else begin
                radix_val = 5'($urandom_range(RADIX_MIN, RADIX_MAX));
            end
            write_config(ADDR_RADIX, radix_val);
            if (items_sent + 40 >= TARGET_ITEMS) begin
                idling_on = 1'b0;
            end
            phase_items = $urandom_range(8, 20);
            repeat (phase_items) send_number(pick_number(radix_val));
        end
        s_tvalid = 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("integer_to_ascii_radix_top verification clean");
        end else begin
            $display("integer_to_ascii_radix_top verification failed");
        end
        $finish;
    end

endmodule
